>>> hdl/sc2a_pkg.sv
package sc2a_pkg;

    // fifo geometry
    localparam int DEPTH  = 128;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CHAR_W = 7;
    localparam int FILL_W = 7;
    localparam int CMP_W  = ((PTR_W + 1) > (FILL_W + 1)) ? (PTR_W + 1) : (FILL_W + 1);

    localparam logic [FILL_W-1:0] FILL_MAX = '1;

    // scancode set 1 codes
    localparam logic [7:0] SC_NONE       = 8'h00;
    localparam logic [7:0] SC_EXT        = 8'he0;
    localparam logic [7:0] SC_LSHIFT_MK  = 8'h2a;
    localparam logic [7:0] SC_RSHIFT_MK  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'haa;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hb6;
    localparam logic [7:0] SC_BREAK_MASK = 8'h80;

    // us keymap, unlisted codes are unmapped
    localparam logic [CHAR_W-1:0] KEYMAP_PLAIN [0:127] = '{
        1: 7'h1b, 2: 7'h31, 3: 7'h32, 4: 7'h33, 5: 7'h34, 6: 7'h35, 7: 7'h36,
        8: 7'h37, 9: 7'h38, 10: 7'h39, 11: 7'h30, 12: 7'h2d, 13: 7'h3d, 14: 7'h08,
        15: 7'h09, 16: 7'h71, 17: 7'h77, 18: 7'h65, 19: 7'h72, 20: 7'h74, 21: 7'h79,
        22: 7'h75, 23: 7'h69, 24: 7'h6f, 25: 7'h70, 26: 7'h5b, 27: 7'h5d, 28: 7'h0d,
        30: 7'h61, 31: 7'h73, 32: 7'h64, 33: 7'h66, 34: 7'h67, 35: 7'h68, 36: 7'h6a,
        37: 7'h6b, 38: 7'h6c, 39: 7'h3b, 40: 7'h27, 41: 7'h60, 43: 7'h5c, 44: 7'h7a,
        45: 7'h78, 46: 7'h63, 47: 7'h76, 48: 7'h62, 49: 7'h6e, 50: 7'h6d, 51: 7'h2c,
        52: 7'h2e, 53: 7'h2f, 55: 7'h2a, 57: 7'h20,
        default: 7'h00
    };

    localparam logic [CHAR_W-1:0] KEYMAP_UPPER [0:127] = '{
        1: 7'h1b, 2: 7'h21, 3: 7'h40, 4: 7'h23, 5: 7'h24, 6: 7'h25, 7: 7'h5e,
        8: 7'h26, 9: 7'h2a, 10: 7'h28, 11: 7'h29, 12: 7'h5f, 13: 7'h2b, 14: 7'h08,
        15: 7'h09, 16: 7'h51, 17: 7'h57, 18: 7'h45, 19: 7'h52, 20: 7'h54, 21: 7'h59,
        22: 7'h55, 23: 7'h49, 24: 7'h4f, 25: 7'h50, 26: 7'h7b, 27: 7'h7d, 28: 7'h0d,
        30: 7'h41, 31: 7'h53, 32: 7'h44, 33: 7'h46, 34: 7'h47, 35: 7'h48, 36: 7'h4a,
        37: 7'h4b, 38: 7'h4c, 39: 7'h3a, 40: 7'h22, 41: 7'h7e, 43: 7'h7c, 44: 7'h5a,
        45: 7'h58, 46: 7'h43, 47: 7'h56, 48: 7'h42, 49: 7'h4e, 50: 7'h4d, 51: 7'h3c,
        52: 7'h3e, 53: 7'h3f, 55: 7'h2a, 57: 7'h20,
        default: 7'h00
    };

    // request from the decoder to the fifo control
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [CHAR_W-1:0] ch;
    } t_fifo_req;

    // outcome of one beat at the fifo
    typedef struct packed {
        logic              pop_ok;
        logic              drop;
        logic [FILL_W-1:0] fill;
    } t_fifo_status;

endpackage

>>> hdl/scancode_to_ascii_fifo.sv
// scancode set 1 to ascii translator with a character fifo
//
// input channel (i_in_valid / o_in_ready): each beat is either a raw
// scancode byte (i_mode 0) or a read request (i_mode 1). shift make/break
// codes update the shift flag, other make codes are translated through the
// us keymap, a mapped character is queued; a read pops the oldest one.
// output channel (o_out_valid / i_out_ready): exactly one result beat per
// input beat, in order: char_ready/char_out for reads, dropped when the
// fifo was full, and the shift flag and fill level after the item.
// after an input accept the beat passes the middle stage, then the output
// register, before o_out_valid rises; throughput is one item per cycle
// while the receiver does not stall, set by the pointer update and the
// one write or one read of the character memory per beat.
// the memory read is registered, so a popped character lands in a middle
// stage and is taken into the output register when that stage moves on.
// reset clears the pointers, the shift flag and both valid stages; memory
// contents are left as they are. when the receiver stalls the output holds
// and the middle stage still takes one more beat before o_in_ready drops.
module scancode_to_ascii_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_mode,
    input  logic [7:0]                  i_scancode,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_char_ready,
    output logic [sc2a_pkg::CHAR_W-1:0] o_char_out,
    output logic                        o_dropped,
    output logic                        o_shift_active,
    output logic [sc2a_pkg::FILL_W-1:0] o_fill_level
);

    logic                         accept;
    logic                         s1_adv;
    logic                         shift_set;
    logic                         shift_clr;
    logic                         is_make;
    logic [sc2a_pkg::CHAR_W-1:0]  ch;
    sc2a_pkg::t_fifo_req          req;
    sc2a_pkg::t_fifo_status       status;
    logic [sc2a_pkg::CHAR_W-1:0]  rdata;

    // shift flag
    logic r_shift;
    logic n_shift;

    // middle stage: result fields waiting for the memory read data
    logic                         r_s1_valid;
    logic                         r_s1_char_ready;
    logic                         r_s1_dropped;
    logic                         r_s1_shift;
    logic [sc2a_pkg::FILL_W-1:0]  r_s1_fill;

    // output register
    logic                         r_out_valid;
    logic                         r_out_char_ready;
    logic [sc2a_pkg::CHAR_W-1:0]  r_out_char;
    logic                         r_out_dropped;
    logic                         r_out_shift;
    logic [sc2a_pkg::FILL_W-1:0]  r_out_fill;

    // handshake: middle stage moves on when the output register is free
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    // decode of the scancode byte
    assign shift_set = !i_mode && (i_scancode == sc2a_pkg::SC_LSHIFT_MK ||
                                   i_scancode == sc2a_pkg::SC_RSHIFT_MK);
    assign shift_clr = !i_mode && (i_scancode == sc2a_pkg::SC_LSHIFT_BRK ||
                                   i_scancode == sc2a_pkg::SC_RSHIFT_BRK);
    // break codes and the extended prefix are ignored, as is the null byte
    assign is_make   = !i_mode && ((i_scancode & sc2a_pkg::SC_BREAK_MASK) == 8'h00) &&
                       i_scancode != sc2a_pkg::SC_NONE && i_scancode != sc2a_pkg::SC_EXT &&
                       !shift_set;

    assign ch = r_shift ? sc2a_pkg::KEYMAP_UPPER[i_scancode[6:0]]
                        : sc2a_pkg::KEYMAP_PLAIN[i_scancode[6:0]];

    assign req.push = is_make && (ch != '0);
    assign req.pop  = i_mode;
    assign req.ch   = ch;

    always_comb begin
        n_shift = r_shift;
        if (accept && shift_set) begin
            n_shift = 1'b1;
        end else if (accept && shift_clr) begin
            n_shift = 1'b0;
        end
    end

    sc2a_fifo_ctrl u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (req),
        .o_status (status),
        .o_rdata  (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_shift <= n_shift;
            if (o_in_ready) begin
                r_s1_valid <= accept;
            end
            if (!r_out_valid || i_out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_char_ready <= status.pop_ok;
            r_s1_dropped    <= status.drop;
            r_s1_shift      <= n_shift;
            r_s1_fill       <= status.fill;
        end
        if (s1_adv) begin
            r_out_char_ready <= r_s1_char_ready;
            r_out_char       <= r_s1_char_ready ? rdata : '0;
            r_out_dropped    <= r_s1_dropped;
            r_out_shift      <= r_s1_shift;
            r_out_fill       <= r_s1_fill;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_char_ready   = r_out_char_ready;
    assign o_char_out     = r_out_char;
    assign o_dropped      = r_out_dropped;
    assign o_shift_active = r_out_shift;
    assign o_fill_level   = r_out_fill;

    // a beat cannot both pop a character and drop one
    a_pop_xor_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !(r_s1_char_ready && r_s1_dropped))
        else $error("pop and drop in the same beat");

    // no character shown unless a read returned one
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_char_ready) |-> (r_out_char == '0))
        else $error("char_out nonzero without char_ready");

    // a stalled middle stage keeps its beat
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> r_s1_valid)
        else $error("middle stage beat lost");

    // input is never taken while the middle stage is stuck
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted into a full pipeline");

endmodule

>>> hdl/sc2a_ram.sv
module sc2a_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sc2a_fifo_ctrl.sv
module sc2a_fifo_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  sc2a_pkg::t_fifo_req        i_req,
    output sc2a_pkg::t_fifo_status     o_status,
    output logic [sc2a_pkg::CHAR_W-1:0] o_rdata
);

    logic [sc2a_pkg::PTR_W-1:0] r_wp;
    logic [sc2a_pkg::PTR_W-1:0] r_rp;
    logic [sc2a_pkg::PTR_W-1:0] n_wp;
    logic [sc2a_pkg::PTR_W-1:0] n_rp;
    logic [sc2a_pkg::PTR_W-1:0] wp_inc;
    logic [sc2a_pkg::PTR_W-1:0] rp_inc;
    logic                       empty;
    logic                       full;
    logic                       do_push;
    logic                       do_pop;
    logic [sc2a_pkg::CMP_W-1:0] diff;

    // wrap at depth, which need not be a power of two
    assign wp_inc = (r_wp == sc2a_pkg::PTR_W'(sc2a_pkg::DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign rp_inc = (r_rp == sc2a_pkg::PTR_W'(sc2a_pkg::DEPTH - 1)) ? '0 : r_rp + 1'b1;
    assign empty  = (r_wp == r_rp);
    assign full   = (wp_inc == r_rp);

    assign do_push = i_accept && i_req.push && !full;
    assign do_pop  = i_accept && i_req.pop && !empty;

    assign n_wp = do_push ? wp_inc : r_wp;
    assign n_rp = do_pop  ? rp_inc : r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
        end
    end

    // occupancy after this beat, saturated to the field width
    always_comb begin
        diff = sc2a_pkg::CMP_W'(n_wp) - sc2a_pkg::CMP_W'(n_rp);
        if (n_wp < n_rp) begin
            diff = diff + sc2a_pkg::CMP_W'(sc2a_pkg::DEPTH);
        end
    end

    assign o_status.pop_ok = i_req.pop && !empty;
    assign o_status.drop   = i_req.push && full;
    assign o_status.fill   = (diff > sc2a_pkg::CMP_W'(sc2a_pkg::FILL_MAX)) ?
                             sc2a_pkg::FILL_MAX : diff[sc2a_pkg::FILL_W-1:0];

    sc2a_ram #(
        .WIDTH (sc2a_pkg::CHAR_W),
        .DEPTH (sc2a_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_wp),
        .i_wdata (i_req.ch),
        .i_re    (do_pop),
        .i_raddr (r_rp),
        .o_rdata (o_rdata)
    );

endmodule

>>> test/tb_scancode_to_ascii_fifo.sv
`timescale 1ns / 1ps

module tb_scancode_to_ascii_fifo;

    // beat kinds on the input channel
    typedef enum logic {
        MODE_KEY  = 1'b0,
        MODE_READ = 1'b1
    } t_beat_mode;

    // one result beat, field order matches the output ports
    typedef struct packed {
        logic                        char_ready;
        logic [sc2a_pkg::CHAR_W-1:0] char_out;
        logic                        dropped;
        logic                        shift_active;
        logic [sc2a_pkg::FILL_W-1:0] fill_level;
    } t_key_result;

    // one row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        t_beat_mode  mode;
        logic [7:0]  code;
        logic        typed;
        t_key_result want;
    } t_key_row;

    localparam int RANDOM_BEATS = 1420;    // beats sent in all before the random part stops
    localparam int LONG_HOLD    = 300;     // receiver hold-off, long enough to back up the input
    localparam int SETTLE       = 8;       // quiet cycles after the last result
    localparam int TIMEOUT_NS   = 4000000; // watchdog limit on the whole run

    // us keymap, set 1 make codes 0x00..0x39; everything above is unmapped
    localparam logic [0:57][6:0] PLAIN_KEYS = {
        7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0d, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
        7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e,
        7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a, 7'h00, 7'h20
    };

    localparam logic [0:57][6:0] SHIFTED_KEYS = {
        7'h00, 7'h1b, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26, 7'h2a,
        7'h28, 7'h29, 7'h5f, 7'h2b, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h0d, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3a,
        7'h22, 7'h7e, 7'h00, 7'h7c, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4e,
        7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a, 7'h00, 7'h20
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic                        i_mode;
    logic [7:0]                  i_scancode;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic                        o_char_ready;
    logic [sc2a_pkg::CHAR_W-1:0] o_char_out;
    logic                        o_dropped;
    logic                        o_shift_active;
    logic [sc2a_pkg::FILL_W-1:0] o_fill_level;

    // predictor state: its own character ring, pointers and shift flag
    logic [sc2a_pkg::CHAR_W-1:0] ring_chars [0:sc2a_pkg::DEPTH-1];
    int                          ring_wr;
    int                          ring_rd;
    logic                        shift_held;

    t_key_result awaited_results [$];
    t_key_row    directed_rows [$];
    int          key_beats;
    int          fail_count;
    bit          quiet;     // segment with no sender gaps
    bit          hold_req;  // sender asks the receiver for one long hold-off

    scancode_to_ascii_fifo u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_scancode     (i_scancode),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_char_ready   (o_char_ready),
        .o_char_out     (o_char_out),
        .o_dropped      (o_dropped),
        .o_shift_active (o_shift_active),
        .o_fill_level   (o_fill_level)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit ring_full();
        return (ring_wr + 1) % sc2a_pkg::DEPTH == ring_rd;
    endfunction

    // translate one accepted beat and advance the predictor state
    task automatic translate_key_beat(input t_beat_mode m, input logic [7:0] code,
                                      output t_key_result r);
        logic [sc2a_pkg::CHAR_W-1:0] ch;
        int                          level;
        r = '0;
        if (m == MODE_READ) begin
            // read pops the oldest character, scancode is don't-care
            if (ring_wr != ring_rd) begin
                r.char_ready = 1'b1;
                r.char_out   = ring_chars[ring_rd];
                ring_rd      = (ring_rd + 1) % sc2a_pkg::DEPTH;
            end
        end else if (code == sc2a_pkg::SC_LSHIFT_MK || code == sc2a_pkg::SC_RSHIFT_MK) begin
            shift_held = 1'b1;
        end else if (code == sc2a_pkg::SC_LSHIFT_BRK || code == sc2a_pkg::SC_RSHIFT_BRK) begin
            shift_held = 1'b0;
        end else if (code != sc2a_pkg::SC_NONE && (code & sc2a_pkg::SC_BREAK_MASK) == 0) begin
            if (code > 8'd57) ch = '0;
            else if (shift_held) ch = SHIFTED_KEYS[code[5:0]];
            else ch = PLAIN_KEYS[code[5:0]];
            // unmapped make codes push nothing; a full ring drops the character
            if (ch != '0) begin
                if (ring_full()) begin
                    r.dropped = 1'b1;
                end else begin
                    ring_chars[ring_wr] = ch;
                    ring_wr             = (ring_wr + 1) % sc2a_pkg::DEPTH;
                end
            end
        end
        level          = (ring_wr + sc2a_pkg::DEPTH - ring_rd) % sc2a_pkg::DEPTH;
        r.shift_active = shift_held;
        r.fill_level   = (level > sc2a_pkg::FILL_MAX) ? sc2a_pkg::FILL_MAX
                                                      : level[sc2a_pkg::FILL_W-1:0];
    endtask

    // offer one beat, hold it until accepted, then queue what it should produce
    task automatic send_beat(input t_beat_mode m, input logic [7:0] code,
                             input logic typed, input t_key_result want);
        t_key_result predicted;
        int          gap;
        gap = quiet ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_scancode <= code;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        translate_key_beat(m, code, predicted);
        awaited_results.push_back(typed ? want : predicted);
        key_beats++;
    endtask

    function automatic t_key_row key_row(t_beat_mode m, logic [7:0] code,
                                         logic typed, t_key_result want);
        t_key_row row;
        row.mode  = m;
        row.code  = code;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // stimulus: reset, directed table, then random segments
    initial begin
        int          seg;
        int          n;
        bit          shifted;
        logic [7:0]  code;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_mode     = MODE_KEY;
        i_scancode = '0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        key_beats  = 0;
        ring_wr    = 0;
        ring_rd    = 0;
        shift_held = 1'b0;

        // result fields: {char_ready, char_out, dropped, shift_active, fill_level}
        // read on empty right after reset, scancode bits all ones are don't-care
        directed_rows.push_back(key_row(MODE_READ, 8'hff, 1'b1, {1'b0, 7'h00, 1'b0, 1'b0, 7'd0}));
        // ignored bytes: null, extended prefix, plain break codes
        directed_rows.push_back(key_row(MODE_KEY, sc2a_pkg::SC_NONE, 1'b1,
                                        {1'b0, 7'h00, 1'b0, 1'b0, 7'd0}));
        directed_rows.push_back(key_row(MODE_KEY, sc2a_pkg::SC_EXT, 1'b1,
                                        {1'b0, 7'h00, 1'b0, 1'b0, 7'd0}));
        directed_rows.push_back(key_row(MODE_KEY, 8'hff, 1'b1, {1'b0, 7'h00, 1'b0, 1'b0, 7'd0}));
        directed_rows.push_back(key_row(MODE_KEY, sc2a_pkg::SC_BREAK_MASK, 1'b1,
                                        {1'b0, 7'h00, 1'b0, 1'b0, 7'd0}));
        // 'a' plain, then shifted with left shift, break of 'a' ignored
        directed_rows.push_back(key_row(MODE_KEY, 8'h1e, 1'b0, '0));
        directed_rows.push_back(key_row(MODE_KEY, sc2a_pkg::SC_LSHIFT_MK, 1'b1,
                                        {1'b0, 7'h00, 1'b0, 1'b1, 7'd1}));
        directed_rows.push_back(key_row(MODE_KEY, 8'h1e, 1'b0, '0));
        directed_rows.push_back(key_row(MODE_KEY, 8'h9e, 1'b1, {1'b0, 7'h00, 1'b0, 1'b1, 7'd2}));
        directed_rows.push_back(key_row(MODE_KEY, sc2a_pkg::SC_LSHIFT_BRK, 1'b1,
                                        {1'b0, 7'h00, 1'b0, 1'b0, 7'd2}));
        // right shift with digit and punctuation keys
        directed_rows.push_back(key_row(MODE_KEY, sc2a_pkg::SC_RSHIFT_MK, 1'b1,
                                        {1'b0, 7'h00, 1'b0, 1'b1, 7'd2}));
        directed_rows.push_back(key_row(MODE_KEY, 8'h02, 1'b0, '0));
        directed_rows.push_back(key_row(MODE_KEY, 8'h35, 1'b0, '0));
        directed_rows.push_back(key_row(MODE_KEY, sc2a_pkg::SC_RSHIFT_BRK, 1'b1,
                                        {1'b0, 7'h00, 1'b0, 1'b0, 7'd4}));
        // highest make code and a hole in the keymap, both unmapped
        directed_rows.push_back(key_row(MODE_KEY, 8'h7f, 1'b0, '0));
        directed_rows.push_back(key_row(MODE_KEY, 8'h1d, 1'b0, '0));
        // last mapped code (space) and the first one (escape)
        directed_rows.push_back(key_row(MODE_KEY, 8'h39, 1'b0, '0));
        directed_rows.push_back(key_row(MODE_KEY, 8'h01, 1'b0, '0));
        // drain all six characters, first one is a plain 'a'
        directed_rows.push_back(key_row(MODE_READ, 8'h00, 1'b1, {1'b1, 7'h61, 1'b0, 1'b0, 7'd5}));
        directed_rows.push_back(key_row(MODE_READ, 8'h00, 1'b0, '0));
        directed_rows.push_back(key_row(MODE_READ, 8'h55, 1'b0, '0));
        directed_rows.push_back(key_row(MODE_READ, 8'haa, 1'b0, '0));
        directed_rows.push_back(key_row(MODE_READ, 8'h00, 1'b0, '0));
        directed_rows.push_back(key_row(MODE_READ, 8'h00, 1'b0, '0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_beat(directed_rows[k].mode, directed_rows[k].code,
                      directed_rows[k].typed, directed_rows[k].want);

        seg = 0;
        while (key_beats < RANDOM_BEATS) begin
            quiet = ($urandom_range(0, 3) == 0);
            if (seg % 16 == 3) begin
                // fill the ring to the brim, overflow it, then drain past empty;
                // the first time around the receiver also holds off for a while
                hold_req = 1'b1;
                while (!ring_full())
                    send_beat(MODE_KEY, 8'($urandom_range(1, 57)), 1'b0, '0);
                repeat ($urandom_range(1, 8))
                    send_beat(MODE_KEY, 8'($urandom_range(1, 57)), 1'b0, '0);
                while (ring_wr != ring_rd)
                    send_beat(MODE_READ, 8'($urandom), 1'b0, '0);
                repeat ($urandom_range(1, 3))
                    send_beat(MODE_READ, 8'($urandom), 1'b0, '0);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        // well-formed typing: optional shift around make/break pairs
                        shifted = $urandom_range(0, 1);
                        if (shifted)
                            send_beat(MODE_KEY, $urandom_range(0, 1) ? sc2a_pkg::SC_LSHIFT_MK
                                                                     : sc2a_pkg::SC_RSHIFT_MK,
                                      1'b0, '0);
                        n = $urandom_range(1, 12);
                        repeat (n) begin
                            code = 8'($urandom_range(1, 57));
                            if ($urandom_range(0, 7) == 0)
                                send_beat(MODE_KEY, sc2a_pkg::SC_EXT, 1'b0, '0);
                            send_beat(MODE_KEY, code, 1'b0, '0);
                            if ($urandom_range(0, 2) == 0)
                                send_beat(MODE_KEY, code | sc2a_pkg::SC_BREAK_MASK, 1'b0, '0);
                            if ($urandom_range(0, 2) == 0)
                                send_beat(MODE_READ, 8'($urandom), 1'b0, '0);
                        end
                        if (shifted)
                            send_beat(MODE_KEY, $urandom_range(0, 1) ? sc2a_pkg::SC_LSHIFT_BRK
                                                                     : sc2a_pkg::SC_RSHIFT_BRK,
                                      1'b0, '0);
                    end
                    6, 7: begin
                        // noise: any byte, any mode
                        repeat ($urandom_range(1, 20))
                            send_beat(t_beat_mode'($urandom_range(0, 1)), 8'($urandom),
                                      1'b0, '0);
                    end
                    default: begin
                        // a few reads, often running past empty
                        repeat ($urandom_range(1, 10))
                            send_beat(MODE_READ, 8'($urandom), 1'b0, '0);
                    end
                endcase
            end
            seg++;
        end
        i_in_valid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // receiver ready: random stalls, long open stretches, one long hold-off
    initial begin
        bit hold_done;
        int run;
        int stall;
        i_out_ready = 1'b0;
        hold_done   = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                i_out_ready <= 1'b0;
                hold_done = 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            repeat (run) @(posedge i_clk);
            stall = pick_gap();
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    task automatic check_field(input string name, input logic [6:0] want, input logic [6:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // result beats are compared in order against the oldest expectation
    initial fail_count = 0;

    always @(posedge i_clk) begin
        t_key_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("char_ready", 7'(want.char_ready), 7'(o_char_ready));
                check_field("char_out", want.char_out, o_char_out);
                check_field("dropped", 7'(want.dropped), 7'(o_dropped));
                check_field("shift_active", 7'(want.shift_active), 7'(o_shift_active));
                check_field("fill_level", want.fill_level, o_fill_level);
            end
        end
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
